/* rtl/pcdp_pkg.sv */
package pcdp_pkg;

  localparam int MAX_MOTIF_WIDTH_DEF = 32;
  localparam int MAX_BINS_DEF        = 1024;
  localparam int PROB_BITS_DEF       = 16;

  localparam int OP_W      = 2;
  localparam int POS_W     = 5;
  localparam int SHIFT_W   = 11;
  localparam int NT_W      = 2;
  localparam int PROB_W    = 17;
  localparam int OUT_W     = 17;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int DIST_W    = 32;
  localparam int NUM_NT    = 4;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_SHIFT = 2'd0,
    OP_LOAD_COND  = 2'd1,
    OP_EVAL       = 2'd2,
    OP_NONE       = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_MARKOV_ORDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTIF_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_BIN   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR_CUR,
    ST_INIT,
    ST_INIT_WR,
    ST_POS,
    ST_CLR_NXT,
    ST_TERM,
    ST_RD_SRC,
    ST_RD_DST,
    ST_WR_DST,
    ST_OVER,
    ST_OVER_WR,
    ST_FIN_RD,
    ST_FIN_ACC,
    ST_OUT
  } state_t;

endpackage

/* rtl/pcdp_if.sv */
interface pcdp_in_if import pcdp_pkg::*;;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [POS_W-1:0]    motif_pos;
  logic [SHIFT_W-1:0]  shift_a;
  logic [SHIFT_W-1:0]  shift_c;
  logic [SHIFT_W-1:0]  shift_g;
  logic [SHIFT_W-1:0]  shift_t;
  logic [NT_W-1:0]     context_nt;
  logic [PROB_W-1:0]   prob_a;
  logic [PROB_W-1:0]   prob_c;
  logic [PROB_W-1:0]   prob_g;
  logic [PROB_W-1:0]   prob_t;
  modport source (output valid, operation, motif_pos, shift_a, shift_c, shift_g, shift_t,
                  context_nt, prob_a, prob_c, prob_g, prob_t, input ready);
  modport sink (input valid, operation, motif_pos, shift_a, shift_c, shift_g, shift_t,
                context_nt, prob_a, prob_c, prob_g, prob_t, output ready);
endinterface

interface pcdp_out_if import pcdp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OUT_W-1:0]  pass_probability;
  modport source (output valid, pass_probability, input ready);
  modport sink (input valid, pass_probability, output ready);
endinterface

/* rtl/pcdp_mac.sv */
// Weighted saturating accumulate: sum = sat32(acc + round(d * p / 2^PROB_BITS)).
// Product is registered on ld; the add is combinational on it, so sum is ready in the cycle after ld.
module pcdp_mac import pcdp_pkg::*; #(
  parameter int PROB_BITS = PROB_BITS_DEF
) (
  input  logic              clk,
  input  logic              ld,
  input  logic [DIST_W-1:0] d,
  input  logic [PROB_W-1:0] p,
  input  logic [DIST_W-1:0] acc,
  output logic [DIST_W-1:0] sum
);
  localparam int PRD_W = DIST_W + PROB_W;
  localparam int RND_W = PRD_W + 1;
  localparam int SUM_W = RND_W + 1;
  localparam logic [RND_W-1:0] HALF = RND_W'(1) << (PROB_BITS - 1);

  logic [PRD_W-1:0] prod_r;
  logic [RND_W-1:0] wtd;
  logic [SUM_W-1:0] tot;

  always_ff @(posedge clk) begin
    if (ld) begin
      prod_r <= PRD_W'(d) * PRD_W'(p);
    end
  end

  assign wtd = (RND_W'(prod_r) + HALF) >> PROB_BITS;
  assign tot = SUM_W'(acc) + SUM_W'(wtd);
  assign sum = (tot > SUM_W'({DIST_W{1'b1}})) ? {DIST_W{1'b1}} : tot[DIST_W-1:0];
endmodule

/* rtl/pwm_cutoff_probability_dp.sv */
// Channel | Dir | Signals                                   | Transfer
// in_ch   | in  | operation, motif_pos, shift_*, context_nt,| valid & ready
//         |     | prob_*                                    |
// out_ch  | out | pass_probability                          | valid & ready
// cfg_*   | in  | cfg_we, cfg_index, cfg_wdata              | cfg_we
//
// An evaluation steps one shared multiply-accumulate over a distribution RAM with
// one read and one write port: it clears four slots of cut+1 bins, then per
// position clears S slots of the next bank (S = 1, or 4 in first-order mode) and
// spreads each nonzero term (T = 4, or 16 in first-order mode) bin by bin, with
// cut = min(cutoff register, MAX_BINS+1). Reset (synchronous, rst_n low) clears
// control and config; tables stay unknown. in_ch.ready is high only when idle.
module pwm_cutoff_probability_dp import pcdp_pkg::*; #(
  parameter int MAX_MOTIF_WIDTH = MAX_MOTIF_WIDTH_DEF,
  parameter int MAX_BINS        = MAX_BINS_DEF,
  parameter int PROB_BITS       = PROB_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  pcdp_in_if.sink              in_ch,
  pcdp_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);
  localparam int BW = $clog2(MAX_BINS + 2);          // bin index width
  localparam int AW = BW + 3;                        // bank, slot, bin
  localparam int PW = $clog2(MAX_MOTIF_WIDTH + 1);   // position counter
  localparam int SW = (MAX_MOTIF_WIDTH > 1) ? $clog2(MAX_MOTIF_WIDTH) : 1;
  localparam int TW = ((BW > SHIFT_W) ? BW : SHIFT_W) + 1;
  localparam int TOT_W = DIST_W + 2;
  localparam logic [BW-1:0]     CUT_MAX = BW'(MAX_BINS + 1);
  localparam logic [DIST_W-1:0] ONE     = DIST_W'(64'd1 << PROB_BITS);

  // config registers
  logic               mo_r;
  logic [5:0]         len_r;
  logic [CFG_W-1:0]   cutcfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mo_r     <= 1'b0;
      len_r    <= 6'd8;
      cutcfg_r <= 11'd1025;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MARKOV_ORDER: mo_r     <= cfg_wdata[0];
        CFG_MOTIF_LENGTH: len_r    <= cfg_wdata[5:0];
        CFG_CUTOFF_BIN:   cutcfg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamped cutoff and length
  logic [BW-1:0] cut;
  logic [PW-1:0] len_eff;
  assign cut = (32'(cutcfg_r) > 32'(MAX_BINS + 1)) ? CUT_MAX : BW'(cutcfg_r);
  assign len_eff = (len_r == 6'd0) ? PW'(1) :
                   (32'(len_r) > 32'(MAX_MOTIF_WIDTH)) ? PW'(MAX_MOTIF_WIDTH) : PW'(len_r);

  // shift rows: one row of four shifts per position
  logic [NUM_NT*SHIFT_W-1:0] shmem [MAX_MOTIF_WIDTH];
  logic [NUM_NT*SHIFT_W-1:0] shrow_r;
  logic                      sh_re;
  logic [SW-1:0]             sh_raddr;
  logic                      sh_we;

  always_ff @(posedge clk) begin
    if (sh_we) begin
      shmem[SW'(in_ch.motif_pos)] <= {in_ch.shift_t, in_ch.shift_g, in_ch.shift_c,
                                      in_ch.shift_a};
    end
    if (sh_re) begin
      shrow_r <= shmem[sh_raddr];
    end
  end

  // conditional rows, marginal probabilities
  logic [PROB_W-1:0] cond_r [16];
  logic [PROB_W-1:0] marg_r [NUM_NT];
  logic              in_xfer;
  assign in_xfer = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (in_xfer && in_ch.operation == OP_LOAD_COND) begin
      cond_r[{in_ch.context_nt, 2'd0}] <= in_ch.prob_a;
      cond_r[{in_ch.context_nt, 2'd1}] <= in_ch.prob_c;
      cond_r[{in_ch.context_nt, 2'd2}] <= in_ch.prob_g;
      cond_r[{in_ch.context_nt, 2'd3}] <= in_ch.prob_t;
    end
    if (in_xfer && in_ch.operation == OP_EVAL) begin
      marg_r[0] <= in_ch.prob_a;
      marg_r[1] <= in_ch.prob_c;
      marg_r[2] <= in_ch.prob_g;
      marg_r[3] <= in_ch.prob_t;
    end
  end

  // distribution RAM: {bank, slot, bin}
  logic [DIST_W-1:0] dmem [1 << AW];
  logic [DIST_W-1:0] d_rdata_r;
  logic [AW-1:0]     d_raddr;
  logic              d_we;
  logic [AW-1:0]     d_waddr;
  logic [DIST_W-1:0] d_wdata;

  always_ff @(posedge clk) begin
    if (d_we) begin
      dmem[d_waddr] <= d_wdata;
    end
    d_rdata_r <= dmem[d_raddr];
  end

  // sequencer registers
  state_t             state_r, state_nxt;
  logic               bank_r, bank_nxt;
  logic [1:0]         slot_r, slot_nxt;   // clear slot, source slot, final slot
  logic [1:0]         nt_r, nt_nxt;
  logic [BW-1:0]      b_r, b_nxt;
  logic [BW-1:0]      t_r, t_nxt;
  logic [PW-1:0]      pos_r, pos_nxt;
  logic [DIST_W-1:0]  over_r, over_nxt;
  logic [TOT_W-1:0]   total_r, total_nxt;
  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r;
  logic               out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      bank_r  <= 1'b0;
      slot_r  <= 2'd0;
      nt_r    <= 2'd0;
      b_r     <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      bank_r  <= bank_nxt;
      slot_r  <= slot_nxt;
      nt_r    <= nt_nxt;
      b_r     <= b_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r     <= t_nxt;
    over_r  <= over_nxt;
    total_r <= total_nxt;
  end

  // term operands
  logic [PROB_W-1:0]  p_cur;
  logic [SHIFT_W-1:0] sh_cur;
  logic [TW-1:0]      t_cur;
  logic [1:0]         dslot;
  logic [1:0]         last_slot;
  logic [BW-1:0]      init_bin;
  logic [DIST_W:0]    over_sum;

  assign p_cur     = mo_r ? cond_r[{slot_r, nt_r}] : marg_r[nt_r];
  assign sh_cur    = shrow_r[32'(nt_r) * SHIFT_W +: SHIFT_W];
  assign t_cur     = TW'(b_r) + TW'(sh_cur);
  assign dslot     = mo_r ? nt_r : 2'd0;
  assign last_slot = mo_r ? 2'd3 : 2'd0;
  assign init_bin  = (TW'(sh_cur) > TW'(cut)) ? cut : BW'(sh_cur);
  assign over_sum  = (DIST_W + 1)'(over_r) + (DIST_W + 1)'(d_rdata_r);

  // shared multiply-accumulate
  logic              mac_ld;
  logic [DIST_W-1:0] mac_d;
  logic [DIST_W-1:0] mac_sum;

  assign mac_d = (state_r == ST_OVER) ? over_r : d_rdata_r;

  pcdp_mac #(.PROB_BITS(PROB_BITS)) u_mac (
    .clk (clk),
    .ld  (mac_ld),
    .d   (mac_d),
    .p   (p_cur),
    .acc (d_rdata_r),
    .sum (mac_sum)
  );

  // result with saturation to 1.0 and to the field maximum
  logic [TOT_W-1:0] res_one;
  logic [OUT_W-1:0] res_out;
  assign res_one = (total_r > TOT_W'(ONE)) ? TOT_W'(ONE) : total_r;
  assign res_out = (res_one > TOT_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : res_one[OUT_W-1:0];

  always_comb begin
    state_nxt = state_r;
    bank_nxt  = bank_r;
    slot_nxt  = slot_r;
    nt_nxt    = nt_r;
    b_nxt     = b_r;
    t_nxt     = t_r;
    pos_nxt   = pos_r;
    over_nxt  = over_r;
    total_nxt = total_r;
    sh_we     = 1'b0;
    sh_re     = 1'b0;
    sh_raddr  = '0;
    d_raddr   = '0;
    d_we      = 1'b0;
    d_waddr   = '0;
    d_wdata   = '0;
    mac_ld    = 1'b0;
    out_load  = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_ch.operation == OP_LOAD_SHIFT &&
              32'(in_ch.motif_pos) < 32'(MAX_MOTIF_WIDTH)) begin
            sh_we = 1'b1;
          end
          if (in_ch.operation == OP_EVAL) begin
            if (cut == '0) begin
              total_nxt = TOT_W'(ONE);
              state_nxt = ST_OUT;
            end else begin
              slot_nxt  = 2'd0;
              b_nxt     = '0;
              state_nxt = ST_CLR_CUR;
            end
          end
        end
      end
      ST_CLR_CUR: begin
        d_we    = 1'b1;
        d_waddr = {bank_r, slot_r, b_r};
        if (b_r == cut) begin
          b_nxt = '0;
          if (slot_r == 2'd3) begin
            state_nxt = ST_INIT;
          end else begin
            slot_nxt = slot_r + 2'd1;
          end
        end else begin
          b_nxt = b_r + BW'(1);
        end
      end
      ST_INIT: begin
        if (mo_r) begin
          sh_re     = 1'b1;
          sh_raddr  = '0;
          nt_nxt    = 2'd0;
          state_nxt = ST_INIT_WR;
        end else begin
          d_we      = 1'b1;
          d_waddr   = {bank_r, 2'd0, BW'(0)};
          d_wdata   = ONE;
          pos_nxt   = '0;
          state_nxt = ST_POS;
        end
      end
      ST_INIT_WR: begin
        // first position in first-order mode: marginal mass, unweighted
        d_we    = 1'b1;
        d_waddr = {bank_r, nt_r, init_bin};
        d_wdata = DIST_W'(marg_r[nt_r]);
        if (nt_r == 2'd3) begin
          pos_nxt   = PW'(1);
          state_nxt = ST_POS;
        end else begin
          nt_nxt = nt_r + 2'd1;
        end
      end
      ST_POS: begin
        slot_nxt = 2'd0;
        b_nxt    = '0;
        if (pos_r == len_eff) begin
          total_nxt = '0;
          state_nxt = ST_FIN_RD;
        end else begin
          sh_re     = 1'b1;
          sh_raddr  = SW'(pos_r);
          state_nxt = ST_CLR_NXT;
        end
      end
      ST_CLR_NXT: begin
        d_we    = 1'b1;
        d_waddr = {~bank_r, slot_r, b_r};
        if (b_r == cut) begin
          b_nxt = '0;
          if (slot_r == last_slot) begin
            slot_nxt  = 2'd0;
            nt_nxt    = 2'd0;
            state_nxt = ST_TERM;
          end else begin
            slot_nxt = slot_r + 2'd1;
          end
        end else begin
          b_nxt = b_r + BW'(1);
        end
      end
      ST_TERM: begin
        b_nxt    = '0;
        over_nxt = '0;
        if (p_cur == '0) begin
          state_nxt = ST_OVER;   // over is zero: falls through to next term
        end else begin
          state_nxt = ST_RD_SRC;
        end
      end
      ST_RD_SRC: begin
        d_raddr   = {bank_r, slot_r, b_r};
        state_nxt = ST_RD_DST;
      end
      ST_RD_DST: begin
        if (t_cur <= TW'(cut)) begin
          d_raddr   = {~bank_r, dslot, BW'(t_cur)};
          t_nxt     = BW'(t_cur);
          mac_ld    = 1'b1;
          state_nxt = ST_WR_DST;
        end else begin
          over_nxt = over_sum[DIST_W] ? {DIST_W{1'b1}} : over_sum[DIST_W-1:0];
          if (b_r == cut) begin
            state_nxt = ST_OVER;
          end else begin
            b_nxt     = b_r + BW'(1);
            state_nxt = ST_RD_SRC;
          end
        end
      end
      ST_WR_DST: begin
        d_we    = 1'b1;
        d_waddr = {~bank_r, dslot, t_r};
        d_wdata = mac_sum;
        if (b_r == cut) begin
          state_nxt = ST_OVER;
        end else begin
          b_nxt     = b_r + BW'(1);
          state_nxt = ST_RD_SRC;
        end
      end
      ST_OVER, ST_OVER_WR: begin
        if (state_r == ST_OVER && over_r != '0) begin
          // fold the overflow mass into the cutoff bin
          d_raddr   = {~bank_r, dslot, cut};
          mac_ld    = 1'b1;
          state_nxt = ST_OVER_WR;
        end else begin
          if (state_r == ST_OVER_WR) begin
            d_we    = 1'b1;
            d_waddr = {~bank_r, dslot, cut};
            d_wdata = mac_sum;
          end
          if (slot_r == last_slot) begin
            slot_nxt = 2'd0;
            if (nt_r == 2'd3) begin
              bank_nxt  = ~bank_r;
              pos_nxt   = pos_r + PW'(1);
              state_nxt = ST_POS;
            end else begin
              nt_nxt    = nt_r + 2'd1;
              state_nxt = ST_TERM;
            end
          end else begin
            slot_nxt  = slot_r + 2'd1;
            state_nxt = ST_TERM;
          end
        end
      end
      ST_FIN_RD: begin
        d_raddr   = {bank_r, slot_r, cut};
        state_nxt = ST_FIN_ACC;
      end
      ST_FIN_ACC: begin
        total_nxt = total_r + TOT_W'(d_rdata_r);
        if (slot_r == last_slot) begin
          state_nxt = ST_OUT;
        end else begin
          slot_nxt  = slot_r + 2'd1;
          state_nxt = ST_FIN_RD;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res_out;
    end
  end

  assign in_ch.ready             = (state_r == ST_IDLE);
  assign out_ch.valid            = out_valid_r;
  assign out_ch.pass_probability = out_data_r;

  // no RAM writes while idle
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !d_we)
    else $error("distribution write while idle");

  // a new result only comes from the output state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT)
    else $error("result raised outside output state");

  // marginal mode uses a single source distribution
  a_single_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TERM && !mo_r) |-> slot_r == 2'd0)
    else $error("extra source slot in marginal mode");

endmodule

/* verif/pwm_cutoff_probability_dp_tb.sv */
module pwm_cutoff_probability_dp_tb;
  import pcdp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Bin array size: bins 0..MAX_BINS+1, the top one is the saturation bin.
  localparam int NBINS     = MAX_BINS_DEF + 2;
  localparam int MAX_CUT   = MAX_BINS_DEF + 1;
  localparam int PROB_ONE  = 1 << PROB_BITS_DEF;
  localparam longint unsigned SAT32 = 64'hFFFF_FFFF;
  localparam longint unsigned HALF  = 64'd1 << (PROB_BITS_DEF - 1);
  localparam int CYCLE_LIMIT = 8_000_000;

  typedef struct {
    op_t                op;
    logic [POS_W-1:0]   pos;
    logic [SHIFT_W-1:0] shift [NUM_NT];
    logic [NT_W-1:0]    ctx;
    logic [PROB_W-1:0]  prob [NUM_NT];
  } dp_item_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  pcdp_in_if  in_ch ();
  pcdp_out_if out_ch ();

  pwm_cutoff_probability_dp uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the block's tables and registers.
  logic [SHIFT_W-1:0] shift_mem [MAX_MOTIF_WIDTH_DEF*NUM_NT];
  logic [PROB_W-1:0]  cond_mem  [16];
  bit         order_q;
  bit [5:0]   length_q;
  bit [10:0]  cutoff_q;

  // Score distributions, one row per ending nucleotide.
  bit [31:0] mass_cur [NUM_NT][NBINS];
  bit [31:0] mass_nxt [NUM_NT][NBINS];

  // Pass probabilities still owed by the block, oldest first.
  logic [OUT_W-1:0] pass_prob_q [$];

  int  fail_cnt;
  int  cycle_cnt;
  int  hold_cnt;    // receiver hold-off, counted down by the receiver
  bit  no_idle;     // both sides run flat out while set

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic bit [31:0] sat_add(bit [31:0] a, longint unsigned b);
    longint unsigned s;
    s = longint'(a) + b;
    return (s > SAT32) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Shift row srow by sh, weight by p and add into next row drow. Everything that
  // lands past the cutoff is summed first and folded into the cutoff bin.
  function automatic void spread_term(int srow, int drow, int cut, int sh,
                                      longint unsigned p);
    longint unsigned over;
    longint unsigned d;
    int t;
    over = 0;
    if (p == 0) return;
    for (int b = 0; b <= cut; b++) begin
      t = b + sh;
      d = mass_cur[srow][b];
      if (t <= cut) begin
        mass_nxt[drow][t] = sat_add(mass_nxt[drow][t], (d * p + HALF) >> PROB_BITS_DEF);
      end else begin
        over += d;
        if (over > SAT32) over = SAT32;
      end
    end
    if (over != 0)
      mass_nxt[drow][cut] = sat_add(mass_nxt[drow][cut], (over * p + HALF) >> PROB_BITS_DEF);
  endfunction

  function automatic logic [OUT_W-1:0] predict_pass(dp_item_t it);
    int cut;
    int len;
    int s;
    longint unsigned total;
    cut   = (cutoff_q > MAX_CUT) ? MAX_CUT : cutoff_q;
    len   = (length_q == 0) ? 1 : length_q;
    total = 0;
    if (len > MAX_MOTIF_WIDTH_DEF) len = MAX_MOTIF_WIDTH_DEF;
    if (cut == 0) return OUT_W'(PROB_ONE);
    for (int r = 0; r < NUM_NT; r++)
      for (int b = 0; b <= cut; b++) mass_cur[r][b] = '0;
    if (!order_q) begin
      mass_cur[0][0] = PROB_ONE;
      for (int p = 0; p < len; p++) begin
        for (int b = 0; b <= cut; b++) mass_nxt[0][b] = '0;
        for (int n = 0; n < NUM_NT; n++)
          spread_term(0, 0, cut, shift_mem[p*NUM_NT+n], it.prob[n]);
        for (int b = 0; b <= cut; b++) mass_cur[0][b] = mass_nxt[0][b];
      end
      total = mass_cur[0][cut];
    end else begin
      // first position: marginals placed unweighted at the clipped shift
      for (int n = 0; n < NUM_NT; n++) begin
        s = shift_mem[n];
        if (s > cut) s = cut;
        mass_cur[n][s] = sat_add(mass_cur[n][s], it.prob[n]);
      end
      for (int p = 1; p < len; p++) begin
        for (int r = 0; r < NUM_NT; r++)
          for (int b = 0; b <= cut; b++) mass_nxt[r][b] = '0;
        for (int n = 0; n < NUM_NT; n++)
          for (int q = 0; q < NUM_NT; q++)
            spread_term(q, n, cut, shift_mem[p*NUM_NT+n], cond_mem[q*NUM_NT+n]);
        for (int r = 0; r < NUM_NT; r++)
          for (int b = 0; b <= cut; b++) mass_cur[r][b] = mass_nxt[r][b];
      end
      for (int n = 0; n < NUM_NT; n++) total += mass_cur[n][cut];
    end
    if (total > PROB_ONE) total = PROB_ONE;
    return total[OUT_W-1:0];
  endfunction

  // Update shadow state for an accepted transfer and queue its result.
  function automatic void track_transfer(dp_item_t it);
    case (it.op)
      OP_LOAD_SHIFT: begin
        for (int n = 0; n < NUM_NT; n++) shift_mem[it.pos*NUM_NT+n] = it.shift[n];
      end
      OP_LOAD_COND: begin
        for (int n = 0; n < NUM_NT; n++) cond_mem[it.ctx*NUM_NT+n] = it.prob[n];
      end
      OP_EVAL: pass_prob_q.push_back(predict_pass(it));
      default: ;
    endcase
  endfunction

  // Sender: random gap, then hold the item until the block takes it.
  task automatic send_item(dp_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= it.op;
    in_ch.motif_pos  <= it.pos;
    in_ch.shift_a    <= it.shift[0];
    in_ch.shift_c    <= it.shift[1];
    in_ch.shift_g    <= it.shift[2];
    in_ch.shift_t    <= it.shift[3];
    in_ch.context_nt <= it.ctx;
    in_ch.prob_a     <= it.prob[0];
    in_ch.prob_c     <= it.prob[1];
    in_ch.prob_g     <= it.prob[2];
    in_ch.prob_t     <= it.prob[3];
    do @(posedge clk); while (!in_ch.ready);
    track_transfer(it);
  endtask

  // Receiver: check each transfer against the oldest prediction.
  initial begin
    int stall;
    logic [OUT_W-1:0] want;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pass_prob_q.size() == 0) begin
          $error("pass_probability: unexpected transfer, actual %0d",
                 out_ch.pass_probability);
          fail_cnt++;
        end else begin
          want = pass_prob_q.pop_front();
          if (out_ch.pass_probability !== want) begin
            $error("pass_probability: expected %0d, actual %0d", want,
                   out_ch.pass_probability);
            fail_cnt++;
          end
        end
        stall = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Stop offering, wait for every owed result, then let the block settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pass_prob_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Register write; only called with the block idle.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(val);
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_MARKOV_ORDER: order_q  = val[0];
      CFG_MOTIF_LENGTH: length_q = val[5:0];
      CFG_CUTOFF_BIN:   cutoff_q = val[10:0];
      default: ;
    endcase
  endtask

  task automatic configure(int order, int len, int cut);
    drain();
    cfg_write(CFG_MARKOV_ORDER, order);
    cfg_write(CFG_MOTIF_LENGTH, len);
    cfg_write(CFG_CUTOFF_BIN, cut);
  endtask

  // Mostly a proper distribution summing to 1.0, sometimes arbitrary values.
  function automatic void draw_probs(ref dp_item_t it);
    int rest;
    if ($urandom_range(0, 3) == 0) begin
      for (int n = 0; n < NUM_NT; n++) it.prob[n] = PROB_W'($urandom_range(0, PROB_ONE));
    end else begin
      rest = PROB_ONE;
      for (int n = 0; n < NUM_NT - 1; n++) begin
        it.prob[n] = PROB_W'($urandom_range(0, rest));
        rest -= int'(it.prob[n]);
      end
      it.prob[NUM_NT-1] = PROB_W'(rest);
    end
  endfunction

  // Small shifts keep mass inside the grid; now and then a far one.
  function automatic logic [SHIFT_W-1:0] draw_shift();
    return ($urandom_range(0, 7) == 0) ? SHIFT_W'($urandom_range(0, MAX_BINS_DEF))
                                       : SHIFT_W'($urandom_range(0, 12));
  endfunction

  function automatic dp_item_t make_item(op_t op);
    dp_item_t it;
    it.op  = op;
    it.pos = POS_W'($urandom_range(0, MAX_MOTIF_WIDTH_DEF - 1));
    it.ctx = NT_W'($urandom_range(0, NUM_NT - 1));
    for (int n = 0; n < NUM_NT; n++) it.shift[n] = draw_shift();
    draw_probs(it);
    return it;
  endfunction

  task automatic send_eval(int pa, int pc, int pg, int pt);
    dp_item_t it;
    it = make_item(OP_EVAL);
    it.prob[0] = PROB_W'(pa);
    it.prob[1] = PROB_W'(pc);
    it.prob[2] = PROB_W'(pg);
    it.prob[3] = PROB_W'(pt);
    send_item(it);
  endtask

  // Fill both tables so no evaluation ever reads an unwritten entry.
  task automatic test_load_tables();
    dp_item_t it;
    for (int p = 0; p < MAX_MOTIF_WIDTH_DEF; p++) begin
      it = make_item(OP_LOAD_SHIFT);
      it.pos = POS_W'(p);
      if (p == 3) begin
        it.shift[0] = '0;
        it.shift[1] = SHIFT_W'(MAX_BINS_DEF);
        it.shift[2] = SHIFT_W'(MAX_BINS_DEF - 1);
        it.shift[3] = SHIFT_W'(1);
      end
      send_item(it);
    end
    for (int c = 0; c < NUM_NT; c++) begin
      it = make_item(OP_LOAD_COND);
      it.ctx = NT_W'(c);
      if (c == 1) begin
        it.prob[0] = PROB_W'(PROB_ONE);
        it.prob[1] = PROB_W'(PROB_ONE - 1);
        it.prob[2] = '0;
        it.prob[3] = PROB_W'(1);
      end
      send_item(it);
    end
  endtask

  task automatic test_directed();
    dp_item_t it;
    // cutoff bin zero: 1.0 with no convolution
    configure(0, 4, 0);
    send_eval(0, 0, 0, 0);
    send_eval(PROB_ONE, PROB_ONE, PROB_ONE, PROB_ONE);
    // plain zero-order runs, probability extremes
    configure(0, 4, 6);
    send_eval(PROB_ONE, 0, 0, 0);
    send_eval(PROB_ONE - 1, 1, 0, 0);
    send_eval(PROB_ONE / 4, PROB_ONE / 4, PROB_ONE / 4, PROB_ONE / 4);
    send_eval(PROB_ONE, PROB_ONE, PROB_ONE, PROB_ONE);
    // unknown operation gives nothing
    it = make_item(OP_NONE);
    send_item(it);
    send_eval(PROB_ONE / 2, 0, PROB_ONE / 2, 0);
    // motif length zero acts as one, oversized length clips to the maximum
    configure(0, 0, 3);
    send_eval(PROB_ONE / 4, PROB_ONE / 4, PROB_ONE / 4, PROB_ONE / 4);
    configure(1, 63, 5);
    send_eval(PROB_ONE / 4, PROB_ONE / 4, PROB_ONE / 4, PROB_ONE / 4);
    send_eval(PROB_ONE, 0, 0, PROB_ONE);
    // first-order, single position: only the marginal placement
    configure(1, 1, 2047);
    send_eval(PROB_ONE, 1, PROB_ONE - 1, 0);
    // oversized cutoff bin saturates to the top bin
    configure(0, 1, 2047);
    send_eval(PROB_ONE / 4, PROB_ONE / 4, PROB_ONE / 4, PROB_ONE / 4);
    // one long zero-order run at the widest grid
    configure(0, 8, MAX_CUT);
    send_eval(PROB_ONE / 4, PROB_ONE / 4, PROB_ONE / 4, PROB_ONE / 4);
    configure(1, 3, 1);
    send_eval(PROB_ONE / 2, PROB_ONE / 2, 0, 0);
  endtask

  // Random phases; each picks a cheap setting, then a mix of transfers.
  task automatic test_random();
    dp_item_t it;
    int pick;
    for (int ph = 0; ph < 7; ph++) begin
      configure($urandom_range(0, 1), $urandom_range(1, 8), $urandom_range(1, 30));
      no_idle = (ph == 2);
      for (int k = 0; k < 8; k++) begin
        pick = $urandom_range(0, 19);
        if (pick < 3)       it = make_item(OP_LOAD_SHIFT);
        else if (pick < 5)  it = make_item(OP_LOAD_COND);
        else if (pick == 5) it = make_item(OP_NONE);
        else                it = make_item(OP_EVAL);
        send_item(it);
      end
      no_idle = 1'b0;
    end
  endtask

  // Receiver holds off while the sender keeps offering, so the block backs up.
  task automatic test_backpressure();
    configure(0, 2, 5);
    hold_cnt = 400;
    for (int k = 0; k < 6; k++) send_item(make_item(OP_EVAL));
    drain();
  endtask

  initial begin
    fail_cnt  = 0;
    cycle_cnt = 0;
    hold_cnt  = 0;
    no_idle   = 1'b0;
    order_q   = 1'b0;
    length_q  = 6'd8;
    cutoff_q  = 11'd1025;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_MARKOV_ORDER;
    cfg_wdata        <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.operation  <= OP_NONE;
    in_ch.motif_pos  <= '0;
    in_ch.shift_a    <= '0;
    in_ch.shift_c    <= '0;
    in_ch.shift_g    <= '0;
    in_ch.shift_t    <= '0;
    in_ch.context_nt <= '0;
    in_ch.prob_a     <= '0;
    in_ch.prob_c     <= '0;
    in_ch.prob_g     <= '0;
    in_ch.prob_t     <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_load_tables();
    test_directed();
    test_backpressure();
    test_random();

    drain();
    repeat (20) @(posedge clk);
    if (fail_cnt == 0 && pass_prob_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* pwm_cutoff_probability_dp.f */
rtl/pcdp_pkg.sv
rtl/pcdp_if.sv
rtl/pcdp_mac.sv
rtl/pwm_cutoff_probability_dp.sv
verif/pwm_cutoff_probability_dp_tb.sv
